[hdl/tfct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfct_pkg
// Shared types and constants for the threshold frequency count table.
// ----------------------------------------------------------------------------
package tfct_pkg;

    localparam int MODE_W = 2;
    localparam int NODE_W = 10;
    localparam int CNT_W  = 11;

    // count-of-counts block size, a power of two
    localparam int BLOCK  = 32;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] VISIT_ZERO = 2'd0;
    localparam logic [1:0] VISIT_ONE  = 2'd1;
    localparam logic [1:0] VISIT_PAIR = 2'd2;
    localparam logic [1:0] VISIT_MAX  = 2'd3;

    localparam logic [CNT_W-1:0] NODE_TOTAL_RST = 11'd1024;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VISIT_RD,
        ST_VISIT_WR,
        ST_COLOR_RD,
        ST_COLOR_WR,
        ST_OLD_RD,
        ST_OLD_WR,
        ST_NEW_RD,
        ST_NEW_WR,
        ST_Q_WALK,
        ST_Q_DONE
    } state_t;

endpackage

[hdl/threshold_frequency_count_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_frequency_count_table
// Per-node visit counts, per-color counts and a blocked count-of-counts table
// answering "how many colors have a count of at least k".
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass of max(MAX_NODES + 1, MAX_COLORS)
// entries (1025 by default) with in_ready low; configuration writes are taken
// throughout. BLOCK is a power of two, so the block of a count is a shift.
// An add or remove reads and writes the visit count (ST_VISIT_RD/WR) and stops
// there when it does not cross the pair boundary; else it reads and writes the
// color count (ST_COLOR_RD/WR), stopping when that is pinned at zero or at
// MAX_NODES, then updates the entry of the old count (ST_OLD_RD/WR) unless it
// was zero, and of the new count (ST_NEW_RD/WR) unless it is zero. A query
// makes one table read per cycle: single entries up to the first block
// boundary, one stored block sum per whole block, then single entries up to
// node_total; by default at most 92 reads, none when the threshold lies above
// node_total. One item is worked on at a time; a result waits in the output
// register while the next item is taken; a query finishes only when it is free.
module threshold_frequency_count_table
    import tfct_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_COLORS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [NODE_W-1:0] node,
    input  logic [NODE_W-1:0] color,
    input  logic [CNT_W-1:0]  threshold,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CNT_W-1:0]  colors_at_least
);

    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int VAW   = $clog2(MAX_NODES);
    localparam int KAW   = $clog2(MAX_COLORS);
    localparam int CCW   = $clog2(MAX_COLORS + 1);
    localparam int NB    = MAX_NODES / BLOCK + 1;
    localparam int BAW   = (NB > 1) ? $clog2(NB) : 1;
    localparam int RW    = $clog2(BLOCK);
    localparam int IW    = $clog2(MAX_NODES + BLOCK + 1);
    localparam int CLR_N = (MAX_NODES + 1 > MAX_COLORS) ? MAX_NODES + 1 : MAX_COLORS;
    localparam int CLRW  = $clog2(CLR_N);

    state_t state_reg, state_next;

    logic [CLRW-1:0]  clr_reg, clr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] node_total_reg;

    logic             is_add_reg, is_add_next;
    logic [VAW-1:0]   node_reg, node_next;
    logic [KAW-1:0]   color_reg, color_next;
    logic [CW-1:0]    old_reg, old_next;
    logic [CW-1:0]    new_reg, new_next;
    logic [BAW-1:0]   old_blk_reg, old_blk_next;
    logic [BAW-1:0]   new_blk_reg, new_blk_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic             pend_sel_reg, pend_sel_next;
    logic [CNT_W-1:0] colors_reg, colors_next;

    logic [1:0]       visit_mem [MAX_NODES];
    logic [CW-1:0]    color_mem [MAX_COLORS];
    logic [CCW-1:0]   coc_mem   [MAX_NODES + 1];
    logic [CCW-1:0]   bs_mem    [NB];

    logic [1:0]       visit_rdata_reg;
    logic [CW-1:0]    color_rdata_reg;
    logic [CCW-1:0]   coc_rdata_reg;
    logic [CCW-1:0]   bs_rdata_reg;

    logic             visit_we;
    logic [VAW-1:0]   visit_waddr;
    logic [1:0]       visit_wdata;
    logic             color_we;
    logic [KAW-1:0]   color_waddr;
    logic [CW-1:0]    color_wdata;
    logic             coc_we;
    logic [CW-1:0]    coc_waddr;
    logic [CCW-1:0]   coc_wdata;
    logic [CW-1:0]    coc_raddr;
    logic             bs_we;
    logic [BAW-1:0]   bs_waddr;
    logic [CCW-1:0]   bs_wdata;
    logic [BAW-1:0]   bs_raddr;

    logic             accept;
    logic             item_ok;
    logic [31:0]      thr_eff;
    logic [31:0]      n_eff;
    logic             q_empty;
    logic             clr_last;
    logic             visit_shift;
    logic             color_skip;
    logic             walk_stop;
    logic             walk_blk;

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign colors_at_least = colors_reg;
    assign accept          = in_valid && in_ready;

    // decode
    always_comb
    begin
        item_ok     = (32'(node) < MAX_NODES) && (32'(color) < MAX_COLORS);
        thr_eff     = (threshold == '0) ? 32'd1 : 32'(threshold);
        n_eff       = (32'(node_total_reg) > MAX_NODES) ? MAX_NODES : 32'(node_total_reg);
        q_empty     = thr_eff > n_eff;
        clr_last    = (clr_reg == CLRW'(CLR_N - 1));
        visit_shift = is_add_reg ? (visit_rdata_reg == VISIT_ONE)
                                 : (visit_rdata_reg == VISIT_PAIR);
        color_skip  = is_add_reg ? (32'(color_rdata_reg) >= MAX_NODES)
                                 : (color_rdata_reg == '0);
        walk_stop   = (i_reg > IW'(n_reg));
        walk_blk    = (i_reg[RW-1:0] == '0) &&
                      ((IW+1)'(i_reg) + (IW+1)'(BLOCK - 1) <= (IW+1)'(n_reg));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_ADD, MODE_REMOVE:
                        begin
                            if (item_ok)
                                state_next = ST_VISIT_RD;
                        end
                        MODE_QUERY:
                        begin
                            state_next = q_empty ? ST_Q_DONE : ST_Q_WALK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_VISIT_RD: state_next = ST_VISIT_WR;
            ST_VISIT_WR: state_next = visit_shift ? ST_COLOR_RD : ST_IDLE;
            ST_COLOR_RD: state_next = ST_COLOR_WR;
            ST_COLOR_WR:
            begin
                if (color_skip)
                    state_next = ST_IDLE;
                else if (color_rdata_reg != '0)
                    state_next = ST_OLD_RD;
                else
                    state_next = ST_NEW_RD;
            end
            ST_OLD_RD:   state_next = ST_OLD_WR;
            ST_OLD_WR:   state_next = (new_reg != '0) ? ST_NEW_RD : ST_IDLE;
            ST_NEW_RD:   state_next = ST_NEW_WR;
            ST_NEW_WR:   state_next = ST_IDLE;
            ST_Q_WALK:
            begin
                if (walk_stop)
                    state_next = ST_Q_DONE;
            end
            ST_Q_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next        = clr_reg;
        pend_valid_next = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        is_add_next     = is_add_reg;
        node_next       = node_reg;
        color_next      = color_reg;
        old_next        = old_reg;
        new_next        = new_reg;
        old_blk_next    = old_blk_reg;
        new_blk_next    = new_blk_reg;
        i_next          = i_reg;
        n_next          = n_reg;
        acc_next        = acc_reg;
        pend_sel_next   = pend_sel_reg;
        colors_next     = colors_reg;

        visit_we    = 1'b0;
        visit_waddr = node_reg;
        visit_wdata = visit_rdata_reg;
        color_we    = 1'b0;
        color_waddr = color_reg;
        color_wdata = new_reg;
        coc_we      = 1'b0;
        coc_waddr   = new_reg;
        coc_wdata   = coc_rdata_reg + CCW'(1);
        bs_we       = 1'b0;
        bs_waddr    = new_blk_reg;
        bs_wdata    = bs_rdata_reg + CCW'(1);
        coc_raddr   = (state_reg == ST_OLD_RD) ? old_reg : new_reg;
        bs_raddr    = (state_reg == ST_OLD_RD) ? old_blk_reg : new_blk_reg;

        if (pend_valid_reg)
            acc_next = acc_reg + (pend_sel_reg ? CNT_W'(bs_rdata_reg)
                                               : CNT_W'(coc_rdata_reg));

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next    = clr_reg + CLRW'(1);
                visit_we    = 1'b1;
                visit_waddr = clr_reg[VAW-1:0];
                visit_wdata = VISIT_ZERO;
                color_we    = 1'b1;
                color_waddr = clr_reg[KAW-1:0];
                color_wdata = '0;
                coc_we      = 1'b1;
                coc_waddr   = clr_reg[CW-1:0];
                coc_wdata   = '0;
                bs_we       = 1'b1;
                bs_waddr    = clr_reg[BAW-1:0];
                bs_wdata    = '0;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_add_next = (mode == MODE_ADD);
                    node_next   = VAW'(node);
                    color_next  = KAW'(color);
                    i_next      = IW'(thr_eff);
                    n_next      = CW'(n_eff);
                    acc_next    = '0;
                end
            end
            ST_VISIT_WR:
            begin
                if (is_add_reg)
                begin
                    visit_we    = (visit_rdata_reg != VISIT_MAX);
                    visit_wdata = visit_rdata_reg + 2'd1;
                end
                else
                begin
                    visit_we    = (visit_rdata_reg != VISIT_ZERO);
                    visit_wdata = visit_rdata_reg - 2'd1;
                end
            end
            ST_COLOR_WR:
            begin
                old_next     = color_rdata_reg;
                new_next     = is_add_reg ? color_rdata_reg + CW'(1)
                                          : color_rdata_reg - CW'(1);
                old_blk_next = BAW'(color_rdata_reg >> RW);
                new_blk_next = BAW'(new_next >> RW);
                color_we     = !color_skip;
                color_wdata  = new_next;
            end
            ST_OLD_WR:
            begin
                coc_we    = 1'b1;
                coc_waddr = old_reg;
                coc_wdata = coc_rdata_reg - CCW'(1);
                bs_we     = 1'b1;
                bs_waddr  = old_blk_reg;
                bs_wdata  = bs_rdata_reg - CCW'(1);
            end
            ST_NEW_WR:
            begin
                coc_we = 1'b1;
                bs_we  = 1'b1;
            end
            ST_Q_WALK:
            begin
                coc_raddr = i_reg[CW-1:0];
                bs_raddr  = BAW'(i_reg >> RW);
                if (!walk_stop)
                begin
                    pend_valid_next = 1'b1;
                    pend_sel_next   = walk_blk;
                    i_next          = walk_blk ? i_reg + IW'(BLOCK) : i_reg + IW'(1);
                end
            end
            ST_Q_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    colors_next    = acc_reg;
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            node_total_reg <= NODE_TOTAL_RST;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                node_total_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        is_add_reg   <= is_add_next;
        node_reg     <= node_next;
        color_reg    <= color_next;
        old_reg      <= old_next;
        new_reg      <= new_next;
        old_blk_reg  <= old_blk_next;
        new_blk_reg  <= new_blk_next;
        i_reg        <= i_next;
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        pend_sel_reg <= pend_sel_next;
        colors_reg   <= colors_next;
    end

    always_ff @(posedge clk)
    begin
        if (visit_we)
            visit_mem[visit_waddr] <= visit_wdata;
        visit_rdata_reg <= visit_mem[node_reg];
    end

    always_ff @(posedge clk)
    begin
        if (color_we)
            color_mem[color_waddr] <= color_wdata;
        color_rdata_reg <= color_mem[color_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coc_we)
            coc_mem[coc_waddr] <= coc_wdata;
        coc_rdata_reg <= coc_mem[coc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bs_we)
            bs_mem[bs_waddr] <= bs_wdata;
        bs_rdata_reg <= bs_mem[bs_raddr];
    end

endmodule

[hdl/tfct_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfct_checker
// Port-level checks for the threshold frequency count table.
// ----------------------------------------------------------------------------
module tfct_checker
    import tfct_pkg::*;
#(
    parameter int MAX_COLORS = 1024
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [MODE_W-1:0] mode,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CNT_W-1:0]  colors_at_least
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(colors_at_least))
        else $error("result changed while stalled");

    // a real item drops in_ready in the cycle after it is taken
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (mode == MODE_ADD || mode == MODE_REMOVE || mode == MODE_QUERY)
        |=> !in_ready)
        else $error("ready stayed high after an item");

    // a new result is only launched from a busy query
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a query in flight");

    // count cannot exceed the number of colors
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (MAX_COLORS >= 2048) || (32'(colors_at_least) <= MAX_COLORS))
        else $error("result above color count");

endmodule

bind threshold_frequency_count_table tfct_checker #(
    .MAX_COLORS(MAX_COLORS)
) u_tfct_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for threshold_frequency_count_table. An initial block
// fills a queue with items and node_total writes. A falling-edge driver
// presents them on the valid/ready input. A rising-edge monitor keeps shadow
// visit, color and count-of-counts tables, predicts every query answer and
// compares it with each colors_at_least the block returns. Both sides stall
// at random, apart from calm stretches. Stimulus covers a directed opening,
// a run that builds one color count across several blocks, and phases of
// random build-up/tear-down sequences under several node_total settings.
// ----------------------------------------------------------------------------
module testbench;
    import tfct_pkg::*;

    localparam int NODES = 1024;
    localparam int COLORS = 1024;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        bit                is_cfg;
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] color;
        logic [CNT_W-1:0]  threshold;
        logic [CNT_W-1:0]  cfg_value;
    } table_op_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [MODE_W-1:0] mode = '0;
    logic [NODE_W-1:0] node = '0;
    logic [NODE_W-1:0] color = '0;
    logic [CNT_W-1:0]  threshold = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CNT_W-1:0]  colors_at_least;

    // shadow tables
    logic [1:0]       visits [NODES];
    logic [CNT_W-1:0] color_tally [COLORS];
    logic [CNT_W-1:0] tally_hist [NODES+1];
    logic [CNT_W-1:0] shadow_total = NODE_TOTAL_RST;

    table_op_t        op_backlog [$];
    logic [CNT_W-1:0] counts_due [$];

    int unsigned cyc = 0;
    int unsigned quiet = 0;
    int unsigned stuck = 0;
    int unsigned miss_count = 0;
    bit          item_taken = 1'b0;
    logic        calm;

    assign calm = (cyc % 16384) >= 12288;

    threshold_frequency_count_table dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .node            (node),
        .color           (color),
        .threshold       (threshold),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .colors_at_least (colors_at_least)
    );

    always #4 clk = ~clk;

    task automatic note_miss(input string what);
        miss_count++;
        if (miss_count <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic move_color(input logic [NODE_W-1:0] c, input bit up);
        logic [CNT_W-1:0] was;
        logic [CNT_W-1:0] now;
        was = color_tally[c];
        if (up ? (was >= NODES) : (was == 0))
            return;
        now = up ? was + 1'b1 : was - 1'b1;
        if (was != 0)
            tally_hist[was] = tally_hist[was] - 1'b1;
        if (now != 0)
            tally_hist[now] = tally_hist[now] + 1'b1;
        color_tally[c] = now;
    endtask

    task automatic push_item(input logic [MODE_W-1:0] m, input int unsigned n,
                             input int unsigned c, input int unsigned t);
        table_op_t op;
        op.is_cfg = 1'b0;
        op.mode = m;
        op.node = n[NODE_W-1:0];
        op.color = c[NODE_W-1:0];
        op.threshold = t[CNT_W-1:0];
        op.cfg_value = '0;
        op_backlog.insert(op_backlog.size(), op);
    endtask

    task automatic push_cfg(input int unsigned value);
        table_op_t op;
        op.is_cfg = 1'b1;
        op.mode = MODE_UNUSED;
        op.node = '0;
        op.color = '0;
        op.threshold = '0;
        op.cfg_value = value[CNT_W-1:0];
        op_backlog.insert(op_backlog.size(), op);
    endtask

    function automatic int unsigned pick_color();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(0, 7);
        else if (p < 85)
            return $urandom_range(0, 63);
        return $urandom_range(0, COLORS - 1);
    endfunction

    // Mostly well-formed sequences: build a color up through fresh node pairs,
    // tear the last build down, and query around block and range boundaries.
    task automatic random_phase(input int unsigned budget, input int unsigned total);
        int unsigned made;
        int unsigned pick;
        int unsigned span;
        int unsigned base;
        int unsigned hue;
        int unsigned last_base;
        int unsigned last_span;
        int unsigned last_hue;
        bit          have_build;
        int          t;
        logic [MODE_W-1:0] m;
        made = 0;
        have_build = 1'b0;
        last_base = 0;
        last_span = 0;
        last_hue = 0;
        push_cfg(total);
        while (made < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                span = $urandom_range(1, 24);
                base = $urandom_range(0, NODES - span);
                hue = pick_color();
                for (int pass = 0; pass < 2; pass++)
                    for (int i = 0; i < span; i++)
                        push_item(MODE_ADD, base + i, hue, $urandom_range(0, 2047));
                last_base = base;
                last_span = span;
                last_hue = hue;
                have_build = 1'b1;
                made += 2 * span;
            end else if (pick < 34 && have_build) begin
                for (int i = 0; i < last_span; i++) begin
                    hue = ($urandom_range(0, 9) == 0) ? pick_color() : last_hue;
                    push_item(MODE_REMOVE, last_base + i, hue, $urandom_range(0, 2047));
                    made++;
                    if ($urandom_range(0, 3) == 0) begin
                        push_item(MODE_REMOVE, last_base + i, hue, $urandom_range(0, 2047));
                        made++;
                    end
                end
                have_build = 1'b0;
            end else if (pick < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    t = $urandom_range(0, 48);
                else if (pick < 60)
                    t = int'(total) + int'($urandom_range(0, 4)) - 2;
                else if (pick < 75)
                    t = 32 * int'($urandom_range(1, 6)) + int'($urandom_range(0, 2)) - 1;
                else
                    t = $urandom_range(0, 2047);
                if (t < 0)
                    t = 0;
                if (t > 2047)
                    t = 2047;
                push_item(MODE_QUERY, $urandom_range(0, NODES - 1),
                          $urandom_range(0, COLORS - 1), t);
                made++;
            end else begin
                m = MODE_W'($urandom_range(0, 3));
                push_item(m, $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, NODES - 1),
                          pick_color(), $urandom_range(0, 2047));
                if (m != MODE_UNUSED)
                    made++;
            end
        end
    endtask

    // driver
    always @(negedge clk) begin
        table_op_t head;
        bit        launch;
        bit        write_cfg;
        bit        rest;
        launch = 1'b0;
        write_cfg = 1'b0;
        if (rst_n && !(in_valid && !item_taken)) begin
            rest = !calm && ($urandom_range(0, 99) < 20);
            if (op_backlog.size() != 0) begin
                head = op_backlog[0];
                if (head.is_cfg) begin
                    if (quiet >= SETTLE_CYCLES && counts_due.size() == 0) begin
                        write_cfg = 1'b1;
                        cfg_wr_data <= head.cfg_value;
                        void'(op_backlog.pop_front());
                    end
                end else if (!rest) begin
                    launch = 1'b1;
                    mode <= head.mode;
                    node <= head.node;
                    color <= head.color;
                    threshold <= head.threshold;
                    void'(op_backlog.pop_front());
                end
            end
            in_valid <= launch;
            cfg_wr_en <= write_cfg;
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && (calm || $urandom_range(0, 99) >= 20);

    // monitor
    always @(posedge clk) begin
        int lo;
        int hi;
        int total_sum;
        logic [CNT_W-1:0] want;
        if (rst_n) begin
            cyc++;
            item_taken <= in_valid && in_ready;
            if (cfg_wr_en)
                shadow_total = cfg_wr_data;
            if (in_valid && in_ready) begin
                quiet = 0;
                case (mode)
                    MODE_QUERY: begin
                        lo = (threshold == 0) ? 1 : int'(threshold);
                        hi = (shadow_total > NODES) ? NODES : int'(shadow_total);
                        total_sum = 0;
                        for (int i = lo; i <= hi; i++)
                            total_sum += tally_hist[i];
                        counts_due.insert(counts_due.size(), total_sum[CNT_W-1:0]);
                    end
                    MODE_ADD: begin
                        if (visits[node] != VISIT_MAX) begin
                            visits[node] = visits[node] + 1'b1;
                            if (visits[node] == VISIT_PAIR)
                                move_color(color, 1'b1);
                        end
                    end
                    MODE_REMOVE: begin
                        if (visits[node] != VISIT_ZERO) begin
                            visits[node] = visits[node] - 1'b1;
                            if (visits[node] == VISIT_ONE)
                                move_color(color, 1'b0);
                        end
                    end
                    default: ;
                endcase
            end else if (quiet < SETTLE_CYCLES) begin
                quiet++;
            end
            if (out_valid && out_ready) begin
                if (counts_due.size() == 0) begin
                    note_miss($sformatf("unexpected colors_at_least %0d", colors_at_least));
                end else begin
                    want = counts_due.pop_front();
                    if (colors_at_least !== want)
                        note_miss($sformatf("colors_at_least expected %0d got %0d",
                                            want, colors_at_least));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                stuck = 0;
            else
                stuck++;
        end
    end

    always @(posedge clk) begin
        if (stuck >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        foreach (visits[i])
            visits[i] = VISIT_ZERO;
        foreach (color_tally[i])
            color_tally[i] = '0;
        foreach (tally_hist[i])
            tally_hist[i] = '0;

        // directed opening, node_total at its reset value
        push_item(MODE_QUERY, 0, 0, 0);
        push_item(MODE_QUERY, 1023, 1023, 2047);
        push_item(MODE_ADD, 0, 0, 2047);
        push_item(MODE_ADD, 0, 0, 0);
        push_item(MODE_ADD, 0, 0, 1);
        push_item(MODE_ADD, 0, 0, 1);            // visit count stays at max
        push_item(MODE_QUERY, 0, 0, 1);
        push_item(MODE_REMOVE, 0, 0, 0);
        push_item(MODE_REMOVE, 0, 0, 0);         // color drops back to zero
        push_item(MODE_REMOVE, 0, 0, 0);
        push_item(MODE_REMOVE, 0, 0, 0);         // visit count stays at zero
        push_item(MODE_ADD, 1023, 1023, 0);
        push_item(MODE_ADD, 1023, 1023, 0);
        push_item(MODE_REMOVE, 1023, 5, 0);      // drop on a color already at zero
        push_item(MODE_UNUSED, 1023, 1023, 2047);
        push_item(MODE_QUERY, 0, 0, 1024);
        push_item(MODE_QUERY, 0, 0, 1);

        // build one color count across two block boundaries
        push_item(MODE_ADD, 513, 682, 0);
        for (int i = 0; i < 70; i++) begin
            push_item(MODE_ADD, 513, 682, $urandom_range(0, 2047));
            push_item(MODE_REMOVE, 513, 341, $urandom_range(0, 2047));
        end
        push_item(MODE_QUERY, 0, 0, 1024);
        push_item(MODE_QUERY, 0, 0, 1);
        push_cfg(2047);
        push_item(MODE_QUERY, 0, 0, 1024);
        push_cfg(1023);
        push_item(MODE_QUERY, 0, 0, 1000);
        push_item(MODE_ADD, 513, 682, 0);
        push_item(MODE_REMOVE, 513, 682, 0);
        push_item(MODE_QUERY, 0, 0, 1023);

        random_phase(200, 2047);
        random_phase(100, 1);
        random_phase(100, 0);
        random_phase(200, 64);
        random_phase(100, 31);
        random_phase(200, 500);
        random_phase(300, 1024);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || in_valid || counts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (miss_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
